@@ design/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg: shared constants for the triangle face normal block
// Holds the unit constant of the Q1.14 output and the search width.
// ----------------------------------------------------------------------------
package tfn_pkg;
    localparam int UNIT_BITS = 15;          // q ranges 0..16384
    localparam logic [UNIT_BITS-1:0] UNIT_ONE = 15'd16384;
    localparam int OUT_WIDTH = 16;
endpackage

@@ design/tfn_front.sv @@
// ----------------------------------------------------------------------------
// tfn_front: edge and cross product stage
// Forms the edges and their cross product.
// ----------------------------------------------------------------------------
module tfn_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [9*COORD_WIDTH-1:0]      in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3*(4*COORD_WIDTH+3)-1:0] out_cross
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;

    logic signed [COORD_WIDTH-1:0] p [9];
    logic signed [EW-1:0] e1 [3];
    logic signed [EW-1:0] e2 [3];
    logic signed [PW-1:0] pr_reg [6];
    logic signed [PW-1:0] pr_next [6];
    logic v1_reg, v2_reg;
    logic signed [CW-1:0] c_reg [3];
    logic adv1, adv2;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            p[i] = in_data[i*COORD_WIDTH +: COORD_WIDTH];
        end
        for (int i = 0; i < 3; i++) begin
            e1[i] = EW'(p[i]) - EW'(p[3+i]);
            e2[i] = EW'(p[3+i]) - EW'(p[6+i]);
        end
        pr_next[0] = e1[1] * e2[2];
        pr_next[1] = e1[2] * e2[1];
        pr_next[2] = e1[2] * e2[0];
        pr_next[3] = e1[0] * e2[2];
        pr_next[4] = e1[0] * e2[1];
        pr_next[5] = e1[1] * e2[0];
    end

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
        if (adv1) begin
            for (int i = 0; i < 6; i++) pr_reg[i] <= pr_next[i];
        end
        if (adv2) begin
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= CW'(pr_reg[2*i]) - CW'(pr_reg[2*i+1]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_cross[i*(4*COORD_WIDTH+3) +: 4*COORD_WIDTH+3] =
                (4*COORD_WIDTH+3)'(c_reg[i]);
        end
    end
endmodule

@@ design/tfn_queue.sv @@
// ----------------------------------------------------------------------------
// tfn_queue: two-entry queue between front and back
// Decouples the cross product stage from the normalize pipeline.
// ----------------------------------------------------------------------------
module tfn_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wp_reg] <= in_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && push) |=> out_valid)
        else $error("pushed entry not visible");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
endmodule

@@ design/tfn_back.sv @@
// ----------------------------------------------------------------------------
// tfn_back: normalize pipeline
// One stage per bit of q: keep the largest q with (2q-1)^2 * S <= 2^30 * c^2.
// ----------------------------------------------------------------------------
module tfn_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [3*(4*COORD_WIDTH+3)-1:0] in_cross,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [3*tfn_pkg::OUT_WIDTH:0]  out_data
);
    import tfn_pkg::*;
    localparam int CW  = 2 * (COORD_WIDTH + 1) + 1;
    localparam int MW  = CW - 1;                 // magnitude width
    localparam int SW  = 2 * MW + 2;             // sum of squares
    localparam int NS  = UNIT_BITS;              // stages 0..NS-1
    localparam int LW  = 2 * MW + 30;
    localparam int XW  = SW + 2 * UNIT_BITS + 4; // (2q-1)^2 * S with headroom

    // stage 0: magnitudes, stage 1: squares, stage 2: sum, then the search
    logic           v_reg [NS+4];
    logic signed [CW-1:0] c_c [3];
    logic [MW-1:0]  m0_reg [3];
    logic           n0_reg [3];
    logic           n1_reg [3];
    logic [2*MW-1:0] sq_reg [3];
    logic [SW-1:0]  s_c;
    logic [SW-1:0]  s_reg [NS];
    logic [LW-1:0]  lim_reg [NS][3];
    logic [XW-1:0]  d_reg [NS][3];
    logic [XW-1:0]  p_reg [NS][3];
    logic           ng_reg [NS+1][3];
    logic [UNIT_BITS-1:0] q_reg [NS+1][3];
    logic           dg_reg [NS+1];
    logic [UNIT_BITS-1:0] t_c [NS][3];
    logic [XW-1:0]  cand_c [NS][3];
    logic [XW-1:0]  pn_c [NS][3];
    logic           take_c [NS][3];
    logic [3*OUT_WIDTH:0] res_reg;

    // stall whole pipe on output backpressure
    logic go;
    assign go = !v_reg[NS+3] || out_ready;
    assign in_ready = go;
    assign out_valid = v_reg[NS+3];
    assign out_data = res_reg;

    // Track D = (2q-1)^2 * S and P = (2q-1) * S; trying t = q + b gives
    // (2t-1)^2 * S = D + 4b*P + 4b^2*S, so each stage needs only shifts and adds.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_c[i] = in_cross[i*(4*COORD_WIDTH+3) +: CW];
        end
        s_c = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        for (int k = 0; k < NS; k++) begin
            for (int i = 0; i < 3; i++) begin
                t_c[k][i] = q_reg[k][i] + (UNIT_BITS'(1) << (NS-1-k));
                cand_c[k][i] = d_reg[k][i] + (p_reg[k][i] << (NS+1-k))
                               + (XW'(s_reg[k]) << (2*(NS-k)));
                pn_c[k][i] = p_reg[k][i] + (XW'(s_reg[k]) << (NS-k));
                take_c[k][i] = (t_c[k][i] <= UNIT_ONE) &&
                               (cand_c[k][i] <= XW'(lim_reg[k][i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS+4; k++) v_reg[k] <= 1'b0;
        end else if (go) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < NS+4; k++) v_reg[k] <= v_reg[k-1];
        end
        if (go) begin
            for (int i = 0; i < 3; i++) begin
                n0_reg[i] <= c_c[i][CW-1];
                m0_reg[i] <= c_c[i][CW-1] ? MW'(-c_c[i]) : MW'(c_c[i]);
                n1_reg[i] <= n0_reg[i];
                sq_reg[i] <= m0_reg[i] * m0_reg[i];
            end
            s_reg[0] <= s_c;
            dg_reg[0] <= s_c == '0;
            for (int i = 0; i < 3; i++) begin
                lim_reg[0][i] <= LW'(sq_reg[i]) << 30;
                d_reg[0][i] <= XW'(s_c);
                p_reg[0][i] <= -XW'(s_c);
                ng_reg[0][i] <= n1_reg[i];
                q_reg[0][i] <= '0;
            end
            for (int k = 1; k < NS; k++) begin
                s_reg[k] <= s_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    lim_reg[k][i] <= lim_reg[k-1][i];
                    d_reg[k][i] <= take_c[k-1][i] ? cand_c[k-1][i] : d_reg[k-1][i];
                    p_reg[k][i] <= take_c[k-1][i] ? pn_c[k-1][i] : p_reg[k-1][i];
                end
            end
            for (int k = 0; k < NS; k++) begin
                dg_reg[k+1] <= dg_reg[k];
                for (int i = 0; i < 3; i++) begin
                    ng_reg[k+1][i] <= ng_reg[k][i];
                    q_reg[k+1][i] <= take_c[k][i] ? t_c[k][i] : q_reg[k][i];
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (dg_reg[NS])
                    res_reg[i*OUT_WIDTH +: OUT_WIDTH] <= '0;
                else if (ng_reg[NS][i])
                    res_reg[i*OUT_WIDTH +: OUT_WIDTH] <= -OUT_WIDTH'(q_reg[NS][i]);
                else
                    res_reg[i*OUT_WIDTH +: OUT_WIDTH] <= OUT_WIDTH'(q_reg[NS][i]);
            end
            res_reg[3*OUT_WIDTH] <= dg_reg[NS];
        end
    end
endmodule

@@ design/triangle_face_normal.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of a triangle
// Cross product of edges first-second and second-third, normalized to signed Q1.14, rounded to nearest.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   first/second/third x,y,z (COORD_WIDTH each)
// m_axis    out  normal_x, normal_y, normal_z (16 each), degenerate
//
// One triangle per clock sustained while m_axis accepts; an input transfer passes
// two front stages, one in the queue, then three setup stages, the fifteen-stage
// bit-by-bit search and the output register before its output transfer.
// Reset clears all valid flags; payload is not reset.
// A stall on m_ axis holds the back pipe; the two-entry queue lets the
// front keep taking transfers until the queue and both front stages fill.
module triangle_face_normal #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // first_x, first_y, first_z, second_x..z, third_x..z from bit 0 up
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // normal_x, normal_y, normal_z, degenerate, zero fill
    output logic [55:0]              m_tdata
);
    import tfn_pkg::*;
    localparam int XW = 3 * (4 * COORD_WIDTH + 3);

    logic fv, fr, qv, qr;
    logic [XW-1:0] fx, qx;
    logic [3*OUT_WIDTH:0] res;

    tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata[9*COORD_WIDTH-1:0]),
        .out_valid(fv), .out_ready(fr), .out_cross(fx)
    );
    tfn_queue #(.WIDTH(XW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fv), .in_ready(fr), .in_data(fx),
        .out_valid(qv), .out_ready(qr), .out_data(qx)
    );
    tfn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(qv), .in_ready(qr), .in_cross(qx),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );
    assign m_tdata = {7'd0, res};
endmodule
